[rtl/lfcr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfcr_pkg
// Types and constants shared by the length-framed command receiver.
// ----------------------------------------------------------------------------
package lfcr_pkg;

    localparam int FRAME_BYTES_DEFAULT = 64;
    localparam int POS_W = 6;

    // frame phase codes
    localparam logic [1:0] PH_HEAD = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_CMD  = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_LENGTH  = 2'd1;
    localparam logic [1:0] ERR_COMMAND = 2'd2;
    localparam logic [1:0] ERR_TAIL    = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_HEAD_BYTE = 3'd0;
    localparam logic [2:0] REG_TAIL_BYTE = 3'd1;
    localparam logic [2:0] REG_COMMAND_A = 3'd2;
    localparam logic [2:0] REG_COMMAND_B = 3'd3;
    localparam logic [2:0] REG_MAX_LEN   = 3'd4;

    localparam logic [6:0] MAX_LEN_RESET = 7'd48;
    localparam logic [7:0] LEN_MIN       = 8'd4;

    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] tail_byte;
        logic [7:0] command_a;
        logic [7:0] command_b;
        logic [6:0] max_frame_length;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       phase;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] remaining;
        logic [7:0]       command;
    } state_t;

    typedef struct packed {
        logic             stored;
        logic [POS_W-1:0] index;
        logic [7:0]       value;
        logic             done;
        logic [7:0]       command;
        logic [1:0]       error;
    } result_t;

endpackage

[rtl/lfcr_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfcr_step
// Per-byte frame parser: next state and result for one received byte.
// ----------------------------------------------------------------------------
module lfcr_step #(
    parameter int FRAME_BYTES = lfcr_pkg::FRAME_BYTES_DEFAULT
) (
    input  lfcr_pkg::cfg_t    cfg,
    input  lfcr_pkg::state_t  state_cur,
    input  logic [7:0]        rx_byte,
    output lfcr_pkg::state_t  state_nxt,
    output lfcr_pkg::result_t res
);
    import lfcr_pkg::*;

    localparam logic [6:0] LIMIT_CAP = 7'((FRAME_BYTES < 64) ? FRAME_BYTES : 64);

    logic [6:0]       limit;
    logic [7:0]       len_less2;
    logic [POS_W-1:0] pos_inc;
    logic             len_ok;
    logic             cmd_ok;

    assign limit     = (cfg.max_frame_length < LIMIT_CAP) ? cfg.max_frame_length : LIMIT_CAP;
    assign len_less2 = rx_byte - 8'd2;
    assign pos_inc   = state_cur.position + POS_W'(1);
    assign len_ok    = (rx_byte >= LEN_MIN) && (rx_byte <= {1'b0, limit});
    assign cmd_ok    = (rx_byte == cfg.command_a) || (rx_byte == cfg.command_b);

    always_comb begin
        res       = '0;
        state_nxt = state_cur;
        unique case (state_cur.phase)
            PH_HEAD: begin
                if (rx_byte == cfg.head_byte) begin
                    res.stored         = 1'b1;
                    res.value          = rx_byte;
                    state_nxt.phase    = PH_LEN;
                    state_nxt.position = POS_W'(1);
                end
            end
            PH_LEN: begin
                if (len_ok) begin
                    res.stored          = 1'b1;
                    res.index           = state_cur.position;
                    res.value           = rx_byte;
                    state_nxt.phase     = PH_CMD;
                    state_nxt.position  = pos_inc;
                    state_nxt.remaining = len_less2[POS_W-1:0];
                end else begin
                    res.error           = ERR_LENGTH;
                    state_nxt.phase     = PH_HEAD;
                    state_nxt.position  = '0;
                    state_nxt.remaining = '0;
                end
            end
            PH_CMD: begin
                if (cmd_ok) begin
                    res.stored          = 1'b1;
                    res.index           = state_cur.position;
                    res.value           = rx_byte;
                    state_nxt.phase     = PH_DATA;
                    state_nxt.position  = pos_inc;
                    state_nxt.remaining = state_cur.remaining - POS_W'(1);
                    state_nxt.command   = rx_byte;
                end else begin
                    res.error           = ERR_COMMAND;
                    state_nxt.phase     = PH_HEAD;
                    state_nxt.position  = '0;
                    state_nxt.remaining = '0;
                end
            end
            PH_DATA: begin
                if (state_cur.remaining > POS_W'(1)) begin
                    res.stored          = 1'b1;
                    res.index           = state_cur.position;
                    res.value           = rx_byte;
                    state_nxt.position  = pos_inc;
                    state_nxt.remaining = state_cur.remaining - POS_W'(1);
                end else begin
                    if (rx_byte == cfg.tail_byte) begin
                        res.stored  = 1'b1;
                        res.index   = state_cur.position;
                        res.value   = rx_byte;
                        res.done    = 1'b1;
                        res.command = state_cur.command;
                    end else begin
                        res.error = ERR_TAIL;
                    end
                    state_nxt.phase     = PH_HEAD;
                    state_nxt.position  = '0;
                    state_nxt.remaining = '0;
                end
            end
            default: begin
                state_nxt.phase = PH_HEAD;
            end
        endcase
    end

endmodule

[rtl/length_framed_command_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_framed_command_receiver
// Parses head / length / command / data / tail frames from a byte stream.
// ----------------------------------------------------------------------------
// Takes one received byte per clock and returns one result transaction per
// byte from an output register. The parse of a byte is a
// single compare-and-update of the frame state, so a byte is taken every cycle
// as long as the output register is empty or being drained in the same cycle;
// s_tready drops only while a result waits on m_tready. The frame length limit
// is the smallest of max_frame_length, FRAME_BYTES and 64. Configuration must be
// written through cfg_wr_* only while the stream is idle; the block itself does
// not enforce this. There is no clearing pass after reset.
module length_framed_command_receiver #(
    parameter int FRAME_BYTES = lfcr_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_index,
    input  logic [7:0]  cfg_wr_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [5:0] store_index, [13:6] stored_value,
                                    // [21:14] frame_command, [23:22] zero
    output logic        m_tlast,    // frame_done
    output logic [2:0]  m_tuser     // [0] byte_stored, [2:1] frame_error
);
    import lfcr_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t res_reg;
    logic    m_valid_reg;
    logic    s_accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    lfcr_step #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_step (
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .rx_byte   (s_tdata),
        .state_nxt (state_next),
        .res       (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.head_byte        <= '0;
            cfg_reg.tail_byte        <= '0;
            cfg_reg.command_a        <= '0;
            cfg_reg.command_b        <= '0;
            cfg_reg.max_frame_length <= MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_HEAD_BYTE: cfg_reg.head_byte        <= cfg_wr_data;
                REG_TAIL_BYTE: cfg_reg.tail_byte        <= cfg_wr_data;
                REG_COMMAND_A: cfg_reg.command_a        <= cfg_wr_data;
                REG_COMMAND_B: cfg_reg.command_b        <= cfg_wr_data;
                REG_MAX_LEN:   cfg_reg.max_frame_length <= cfg_wr_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase     <= PH_HEAD;
            state_reg.position  <= '0;
            state_reg.remaining <= '0;
            state_reg.command   <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, res_reg.command, res_reg.value, res_reg.index};
    assign m_tlast  = res_reg.done;
    assign m_tuser  = {res_reg.error, res_reg.stored};

`ifndef SYNTHESIS
    a_hunt_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_HEAD |-> state_reg.position == '0 && state_reg.remaining == '0)
        else $error("hunting with nonzero frame counters");

    a_head_found: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && state_reg.phase == PH_HEAD && s_tdata == cfg_reg.head_byte
        |=> state_reg.phase == PH_LEN && m_tvalid && m_tuser[0])
        else $error("head byte not taken into frame");

    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0] && m_tuser[2:1] == ERR_NONE)
        else $error("frame completion with error or unstored tail");

    a_error_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && res_next.error != ERR_NONE |=> state_reg.phase == PH_HEAD)
        else $error("error did not return to head hunting");
`endif

endmodule

[bench/lfcr_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfcr_frame_checker
// Watches the byte and result channels of the length-framed command receiver,
// tracks the register writes, parses every accepted byte with its own frame
// state machine and compares each result transaction field by field with the
// oldest predicted result.
// ----------------------------------------------------------------------------
module lfcr_frame_checker #(
    parameter int FRAME_BYTES = lfcr_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_index,
    input  logic [7:0]  cfg_wr_data,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // [5:0] store_index, [13:6] stored_value,
                                    // [21:14] frame_command, [23:22] zero
    input  logic        m_tlast,    // frame_done
    input  logic [2:0]  m_tuser,    // [0] byte_stored, [2:1] frame_error

    output int          fail_count,
    output int          pending
);

    import lfcr_pkg::*;

    cfg_t    cfg;
    state_t  frame;
    result_t expected_results[$];
    result_t want;
    result_t got;
    int      shown;

    function automatic int length_limit();
        int lim;
        lim = cfg.max_frame_length;
        if (lim > FRAME_BYTES) lim = FRAME_BYTES;
        if (lim > 64) lim = 64;
        return lim;
    endfunction

    function automatic void restart_hunt();
        frame.phase     = PH_HEAD;
        frame.position  = '0;
        frame.remaining = '0;
    endfunction

    function automatic result_t parse_byte(input logic [7:0] rx);
        result_t r;
        r = '0;
        case (frame.phase)
            PH_HEAD: begin
                if (rx == cfg.head_byte) begin
                    r.stored       = 1'b1;
                    r.value        = rx;
                    frame.phase    = PH_LEN;
                    frame.position = 6'd1;
                end
            end
            PH_LEN: begin
                if (rx >= LEN_MIN && int'(rx) <= length_limit()) begin
                    r.stored        = 1'b1;
                    r.index         = frame.position;
                    r.value         = rx;
                    frame.remaining = 6'(rx - 8'd2);
                    frame.phase     = PH_CMD;
                    frame.position  = frame.position + 1'b1;
                end else begin
                    r.error = ERR_LENGTH;
                    restart_hunt();
                end
            end
            PH_CMD: begin
                if (rx == cfg.command_a || rx == cfg.command_b) begin
                    r.stored        = 1'b1;
                    r.index         = frame.position;
                    r.value         = rx;
                    frame.remaining = frame.remaining - 1'b1;
                    frame.command   = rx;
                    frame.phase     = PH_DATA;
                    frame.position  = frame.position + 1'b1;
                end else begin
                    r.error = ERR_COMMAND;
                    restart_hunt();
                end
            end
            default: begin
                if (frame.remaining > 6'd1) begin
                    r.stored        = 1'b1;
                    r.index         = frame.position;
                    r.value         = rx;
                    frame.remaining = frame.remaining - 1'b1;
                    frame.position  = frame.position + 1'b1;
                end else if (rx == cfg.tail_byte) begin
                    r.stored  = 1'b1;
                    r.index   = frame.position;
                    r.value   = rx;
                    r.done    = 1'b1;
                    r.command = frame.command;
                    restart_hunt();
                end else begin
                    r.error = ERR_TAIL;
                    restart_hunt();
                end
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            fail_count++;
            if (shown < 100) begin
                shown++;
                $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg = '0;
            cfg.max_frame_length = MAX_LEN_RESET;
            restart_hunt();
            frame.command = '0;
            expected_results.delete();
            pending = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.stored  = m_tuser[0];
                got.error   = m_tuser[2:1];
                got.index   = m_tdata[5:0];
                got.value   = m_tdata[13:6];
                got.command = m_tdata[21:14];
                got.done    = m_tlast;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result transaction expected none got %0h", $time,
                             {m_tuser, m_tlast, m_tdata});
                end else begin
                    want = expected_results.pop_front();
                    check_field("byte_stored", 8'(want.stored), 8'(got.stored));
                    check_field("store_index", 8'(want.index), 8'(got.index));
                    check_field("stored_value", want.value, got.value);
                    check_field("frame_done", 8'(want.done), 8'(got.done));
                    check_field("frame_command", want.command, got.command);
                    check_field("frame_error", 8'(want.error), 8'(got.error));
                    check_field("tdata padding", 8'h00, 8'(m_tdata[23:22]));
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(parse_byte(s_tdata));
            end
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_HEAD_BYTE: cfg.head_byte = cfg_wr_data;
                    REG_TAIL_BYTE: cfg.tail_byte = cfg_wr_data;
                    REG_COMMAND_A: cfg.command_a = cfg_wr_data;
                    REG_COMMAND_B: cfg.command_b = cfg_wr_data;
                    REG_MAX_LEN:   cfg.max_frame_length = cfg_wr_data[6:0];
                    default: ;
                endcase
            end
            pending = expected_results.size();
        end
    end

endmodule

[bench/length_framed_command_receiver_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_framed_command_receiver_tb
// Drives the length-framed command receiver with a short directed byte
// sequence, then with phases of random settings, each carrying mostly
// well-formed frames with random content plus broken frames and noise, with
// random source gaps and result stalls. The checker module predicts and
// compares every result transaction; this module gives the verdict.
// ----------------------------------------------------------------------------
module length_framed_command_receiver_tb;

    import lfcr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int BYTE_TARGET = 650;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [2:0]  cfg_wr_index = '0;
    logic [7:0]  cfg_wr_data  = '0;
    logic        s_tvalid     = 1'b0;
    logic [7:0]  s_tdata      = '0;
    logic        m_tready     = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;

    int   fail_count;
    int   pending_results;
    int   cycles      = 0;
    int   sink_wait   = 0;
    int   frame_bytes = 0;
    bit   src_gaps    = 1'b1;
    bit   sink_stalls = 1'b1;
    cfg_t cur_cfg;

    logic [7:0] directed_bytes [26] = '{
        8'hFF,
        8'hA5, 8'h04, 8'h00, 8'h5A,
        8'hA5, 8'h05, 8'hFF, 8'h80, 8'h5A,
        8'hA5, 8'h03,
        8'hA5, 8'h41,
        8'hA5, 8'hFF,
        8'hA5, 8'h04, 8'h12,
        8'hA5, 8'h04, 8'h00, 8'h00,
        8'hA5, 8'hA5, 8'h04
    };

    always #4 aclk = ~aclk;

    length_framed_command_receiver u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

    lfcr_frame_checker u_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending_results)
    );

    // result sink: random stall after each transaction, if sink_stalls
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            sink_wait = sink_stalls ? $urandom_range(0, 12) : 0;
        end else if (sink_wait > 0) begin
            sink_wait--;
        end
        m_tready <= (sink_wait == 0);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL length_framed_command_receiver");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit counted);
        int gap;
        gap = src_gaps ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (counted) frame_bytes++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
    endtask

    task automatic write_config(input cfg_t c);
        write_reg(REG_HEAD_BYTE, c.head_byte);
        write_reg(REG_TAIL_BYTE, c.tail_byte);
        write_reg(REG_COMMAND_A, c.command_a);
        write_reg(REG_COMMAND_B, c.command_b);
        write_reg(REG_MAX_LEN, {1'b0, c.max_frame_length});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    // one frame, well-formed or broken where fault says (length if lim < 4)
    task automatic send_frame(input logic [1:0] fault);
        int lim;
        int len;
        logic [7:0] b;
        lim = (cur_cfg.max_frame_length > 64) ? 64 : int'(cur_cfg.max_frame_length);
        send_byte(cur_cfg.head_byte, 1'b1);
        if (fault == ERR_LENGTH || lim < 4) begin
            if (lim >= 64 || $urandom_range(0, 1) == 0) len = $urandom_range(0, 3);
            else len = $urandom_range(lim + 1, 255);
            send_byte(8'(len), 1'b1);
            return;
        end
        if ($urandom_range(0, 7) == 0) len = $urandom_range(4, lim);
        else len = $urandom_range(4, (lim < 10) ? lim : 10);
        send_byte(8'(len), 1'b1);
        if (fault == ERR_COMMAND) begin
            do b = 8'($urandom);
            while (b == cur_cfg.command_a || b == cur_cfg.command_b);
            send_byte(b, 1'b1);
            return;
        end
        send_byte($urandom_range(0, 1) ? cur_cfg.command_a : cur_cfg.command_b, 1'b1);
        repeat (len - 4) send_byte(8'($urandom), 1'b1);
        if (fault == ERR_TAIL) send_byte(cur_cfg.tail_byte ^ 8'($urandom_range(1, 255)), 1'b1);
        else send_byte(cur_cfg.tail_byte, 1'b1);
    endtask

    initial begin
        cfg_t c;
        int r;
        logic [1:0] fault;
        logic [7:0] b;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        write_config('{8'hA5, 8'h5A, 8'h00, 8'hFF, 7'd64});
        foreach (directed_bytes[i]) send_byte(directed_bytes[i], 1'b1);

        while (frame_bytes < BYTE_TARGET) begin
            wait_idle();
            c.head_byte = 8'($urandom);
            c.tail_byte = 8'($urandom);
            c.command_a = 8'($urandom);
            c.command_b = ($urandom_range(0, 7) == 0) ? c.command_a : 8'($urandom);
            case ($urandom_range(0, 7))
                0: c.max_frame_length = 7'd4;
                1: c.max_frame_length = 7'd64;
                2: c.max_frame_length = 7'd127;
                3: c.max_frame_length = 7'($urandom_range(0, 3));
                default: c.max_frame_length = 7'($urandom_range(5, 63));
            endcase
            write_config(c);
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 8)) begin
                repeat ($urandom_range(0, 3)) begin
                    b = 8'($urandom);
                    if (b == cur_cfg.head_byte) b = b ^ 8'h01;
                    send_byte(b, 1'b1);
                end
                r = $urandom_range(0, 9);
                if (r < 6) fault = ERR_NONE;
                else if (r == 6) fault = ERR_LENGTH;
                else if (r == 7) fault = ERR_COMMAND;
                else fault = ERR_TAIL;
                send_frame(fault);
            end
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS length_framed_command_receiver");
        end else begin
            $display("FAIL length_framed_command_receiver");
        end
        $finish;
    end

endmodule
